/* rtl/lbe_pkg.sv */
// Package with shared constants, codes and control types for the Lagrange basis evaluator.
`default_nettype none
package lbe_pkg;
  localparam int MaxNodes = 16;
  localparam int FracBits = 28;
  localparam logic [4:0] NodeCountReset = 5'd2;
  localparam logic [30:0] StepHReset = 31'd1048576;

  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActEval  = 2'd1;
  localparam logic [1:0] ActDeriv = 2'd2;

  localparam logic [1:0] StatOk  = 2'd0;
  localparam logic [1:0] StatSat = 2'd1;
  localparam logic [1:0] StatEq  = 2'd2;

  localparam logic [1:0] RegNodeCount  = 2'd0;
  localparam logic [1:0] RegBasisIndex = 2'd1;
  localparam logic [1:0] RegStepH      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_item;   // latch x, clear flags
    logic start_point;  // set up abscissa for one evaluation pass
    logic [1:0] point;  // which shifted point (0:+2h 1:+h 2:-h 3:-2h, or x)
    logic use_shift;
    logic load_pair;    // set up divider for (pt - node_j) / (node_k - node_j)
    logic mul_step;     // apply factor to product
    logic acc_point;    // add weighted f to the difference sum
    logic start_final;  // set up final division
  } lbe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic den_zero;
  } lbe_stat_t;
endpackage
`default_nettype wire

/* rtl/lbe_div.sv */
// Restoring divider: num * 2^FracBits / den with a cap, one quotient bit per cycle.
`default_nettype none
module lbe_div #(
  parameter int FRAC_BITS = lbe_pkg::FracBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [35:0] num,
  input  wire logic [34:0] den,
  output logic [40:0]      quot,
  output logic             done
);
  localparam int NumW = 36;
  localparam int Steps = NumW + FRAC_BITS;
  localparam int CntW = $clog2(Steps + 1);
  localparam logic [40:0] Cap = 41'h100_0000_0000;

  logic [NumW-1:0] nsh;
  logic [35:0] rem;
  logic [34:0] dreg;
  logic [40:0] q;
  logic capped;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [35:0] rtry;
  logic [41:0] qn;

  always_comb begin
    rtry = {rem[34:0], nsh[NumW-1]};
    qn = {q, 1'b0};
    if (rtry >= {1'b0, dreg}) begin
      rtry = rtry - {1'b0, dreg};
      qn[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        nsh <= num;
        rem <= '0;
        dreg <= den;
        q <= '0;
        capped <= 1'b0;
        cnt <= '0;
      end else if (busy) begin
        nsh <= {nsh[NumW-2:0], 1'b0};
        rem <= rtry;
        if (qn > {1'b0, Cap}) capped <= 1'b1;
        q <= qn[40:0];
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient only grows, so once past the cap it stays capped.
  assign quot = capped ? Cap : ((q > Cap) ? Cap : q);
endmodule
`default_nettype wire

/* rtl/lbe_datapath.sv */
// Datapath: node table, shifted abscissa, factor divider, product and difference sum.
`default_nettype none
module lbe_datapath #(
  parameter int MAX_NODES = lbe_pkg::MaxNodes,
  parameter int FRAC_BITS = lbe_pkg::FracBits,
  localparam int IdxW = $clog2(MAX_NODES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lbe_pkg::lbe_cmd_t  cmd,
  input  wire logic [IdxW-1:0]    j_idx,
  input  wire logic [IdxW-1:0]    k_idx,
  input  wire logic               tbl_we,
  input  wire logic [IdxW-1:0]    tbl_addr,
  input  wire logic signed [31:0] tbl_data,
  input  wire logic signed [31:0] x_in,
  input  wire logic [30:0]        step_h,
  output lbe_pkg::lbe_stat_t      stat,
  output logic signed [31:0]      result,
  output logic                    ovf
);
  localparam logic signed [63:0] One = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SMax = 64'sd2147483647;
  localparam logic signed [63:0] SMin = -64'sd2147483648;

  logic signed [31:0] node_mem [MAX_NODES];
  logic signed [31:0] node_j, node_k;
  logic signed [31:0] x_reg, pt;
  logic signed [31:0] prod;
  logic signed [40:0] sum;
  logic div_start;
  logic [35:0] div_num;
  logic [34:0] div_den;
  logic [40:0] quot;
  logic div_done;
  logic final_phase;
  logic signed [31:0] fac;
  logic fac_neg;

  logic [31:0] h1;
  logic signed [33:0] ptw;
  logic signed [33:0] numw, denw;
  logic [63:0] pm;
  logic signed [41:0] qs;

  always_ff @(posedge clk) begin
    if (tbl_we) node_mem[tbl_addr] <= tbl_data;
    node_j <= node_mem[j_idx];
    node_k <= node_mem[k_idx];
  end

  assign h1 = (step_h == '0) ? 32'd1 : {1'b0, step_h};

  always_comb begin
    unique case (cmd.point)
      2'd0: ptw = 34'(x_reg) + 34'({h1, 1'b0});
      2'd1: ptw = 34'(x_reg) + 34'(h1);
      2'd2: ptw = 34'(x_reg) - 34'(h1);
      default: ptw = 34'(x_reg) - 34'({h1, 1'b0});
    endcase
    if (!cmd.use_shift) ptw = 34'(x_reg);
    numw = 34'(pt) - 34'(node_j);
    denw = 34'(node_k) - 34'(node_j);
    pm = 64'(prod[31] ? -64'(prod) : 64'(prod)) * 64'(fac[31] ? -64'(fac) : 64'(fac));
    qs = fac_neg ? -42'(quot) : 42'(quot);
  end

  assign stat.den_zero = (denw == '0);
  assign stat.div_done = div_done;

  lbe_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quot(quot), .done(div_done)
  );

  logic signed [63:0] pv;
  always_comb begin
    pv = 64'(pm >> FRAC_BITS);
    if (prod[31] != fac[31]) pv = -pv;
  end

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (cmd.start_item) begin
      x_reg <= x_in;
      ovf <= 1'b0;
      sum <= '0;
    end
    if (cmd.start_point) begin
      prod <= 32'(One);
      final_phase <= 1'b0;
      if (64'(ptw) > SMax) begin pt <= 32'(SMax); ovf <= 1'b1; end
      else if (64'(ptw) < SMin) begin pt <= 32'(SMin); ovf <= 1'b1; end
      else pt <= ptw[31:0];
    end
    if (cmd.load_pair) begin
      div_start <= 1'b1;
      div_num <= numw[33] ? 36'(-numw) : 36'(numw);
      div_den <= 35'(denw[33] ? -denw : denw);
      fac_neg <= numw[33] != denw[33];
    end
    if (div_done && !final_phase) begin
      if (qs > 42'(SMax)) begin fac <= 32'(SMax); ovf <= 1'b1; end
      else if (qs < 42'(SMin)) begin fac <= 32'(SMin); ovf <= 1'b1; end
      else fac <= qs[31:0];
    end
    if (cmd.mul_step) begin
      if (pv > SMax) begin prod <= 32'(SMax); ovf <= 1'b1; end
      else if (pv < SMin) begin prod <= 32'(SMin); ovf <= 1'b1; end
      else prod <= pv[31:0];
    end
    if (cmd.acc_point) begin
      unique case (cmd.point)
        2'd0: sum <= sum - 41'(prod);
        2'd1: sum <= sum + (41'(prod) <<< 3);
        2'd2: sum <= sum - (41'(prod) <<< 3);
        default: sum <= sum + 41'(prod);
      endcase
    end
    if (cmd.start_final) begin
      final_phase <= 1'b1;
      div_start <= 1'b1;
      div_num <= 36'(sum[40] ? -sum : sum);
      div_den <= 35'(h1) * 35'd12;
      fac_neg <= sum[40];
    end
    if (div_done && final_phase) begin
      if (qs > 42'(SMax)) begin prod <= 32'(SMax); ovf <= 1'b1; end
      else if (qs < 42'(SMin)) begin prod <= 32'(SMin); ovf <= 1'b1; end
      else prod <= qs[31:0];
    end
    if (rst) final_phase <= 1'b0;
  end

  assign result = prod;
endmodule
`default_nettype wire

/* rtl/lbe_ctrl.sv */
// Controller: sequences node loads, basis passes, derivative points and output handshake.
`default_nettype none
module lbe_ctrl #(
  parameter int MAX_NODES = lbe_pkg::MaxNodes,
  localparam int IdxW = $clog2(MAX_NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [3:0]        node_slot,
  input  wire logic [4:0]        node_count,
  input  wire logic [3:0]        basis_index,
  input  wire lbe_pkg::lbe_stat_t stat,
  input  wire logic signed [31:0] dp_result,
  input  wire logic              dp_ovf,
  output lbe_pkg::lbe_cmd_t      cmd,
  output logic [IdxW-1:0]        j_idx,
  output logic [IdxW-1:0]        k_idx,
  output logic                   tbl_we,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     basis_result,
  output logic [1:0]             status
);
  localparam int CntW = $clog2(MAX_NODES + 1);
  typedef enum logic [3:0] {
    S_IDLE, S_POINT, S_FETCH, S_CHECK, S_DIVW, S_MUL, S_NEXT, S_FINAL, S_FWAIT, S_DONE
  } state_t;

  state_t state;
  logic deriv, zero_res;
  logic [1:0] pidx;
  logic [CntW-1:0] n_eff, jc;
  logic [CntW-1:0] k_ext;
  logic accepted;
  logic pass_end;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accepted = in_valid && in_ready;
  assign tbl_we = accepted && action == lbe_pkg::ActLoad
                  && 32'(node_slot) < 32'(MAX_NODES);
  assign k_ext = CntW'(basis_index);

  always_comb begin
    if (node_count < 5'd2) n_eff = CntW'(2);
    else if (32'(node_count) > 32'(MAX_NODES)) n_eff = CntW'(MAX_NODES);
    else n_eff = CntW'(node_count);
  end

  // With the basis index out of range a pass walks no nodes, but a derivative
  // still forms its shifted points, which may saturate.
  assign pass_end = (jc == n_eff) || zero_res;

  always_comb begin
    cmd = '0;
    cmd.point = pidx;
    cmd.use_shift = deriv;
    cmd.start_item = accepted;
    cmd.start_point = (state == S_POINT);
    cmd.load_pair = (state == S_CHECK) && !stat.den_zero;
    cmd.mul_step = (state == S_MUL);
    cmd.acc_point = (state == S_NEXT) && deriv && pass_end;
    cmd.start_final = (state == S_FINAL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      deriv <= 1'b0;
      pidx <= '0;
      jc <= '0;
      zero_res <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accepted && (action == lbe_pkg::ActEval || action == lbe_pkg::ActDeriv)) begin
            deriv <= (action == lbe_pkg::ActDeriv);
            pidx <= '0;
            zero_res <= (k_ext >= n_eff);
            state <= S_POINT;
          end
        end
        S_POINT: begin
          jc <= '0;
          state <= S_NEXT;
        end
        S_NEXT: begin
          // Entered with jc as the next node to consider.
          if (pass_end) begin
            if (deriv && pidx != 2'd3) begin
              pidx <= pidx + 2'd1;
              state <= S_POINT;
            end else state <= deriv ? S_FINAL : S_DONE;
          end else if (jc == k_ext) jc <= jc + 1'b1;
          else begin
            j_idx <= jc[IdxW-1:0];
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          if (stat.den_zero) begin
            basis_result <= '0;
            status <= lbe_pkg::StatEq;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else state <= S_DIVW;
        end
        S_DIVW: if (stat.div_done) state <= S_MUL;
        S_MUL: begin
          jc <= jc + 1'b1;
          state <= S_NEXT;
        end
        S_FINAL: state <= S_FWAIT;
        S_FWAIT: if (stat.div_done) state <= S_DONE;
        S_DONE: begin
          basis_result <= zero_res ? 32'sd0 : dp_result;
          status <= dp_ovf ? lbe_pkg::StatSat : lbe_pkg::StatOk;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign k_idx = basis_index[IdxW-1:0];
endmodule
`default_nettype wire

/* rtl/lagrange_basis_eval_core.sv */
// Top level of the Lagrange basis evaluator: configuration registers, controller and datapath.
// An evaluate word walks the node table once, with one division per node besides the
// basis node in the bit-serial divider (36 + FRAC_BITS quotient bits).
// A derivative word makes four such passes plus one final division.
// Results wait in an output register; a new word is taken
// once the previous result has been delivered.
`default_nettype none
module lagrange_basis_eval_core #(
  parameter int MAX_NODES = lbe_pkg::MaxNodes,
  parameter int FRAC_BITS = lbe_pkg::FracBits
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         action,
  input  wire logic [3:0]         node_slot,
  input  wire logic signed [31:0] node_value,
  input  wire logic signed [31:0] eval_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      basis_result,
  output logic [1:0]              status
);
  localparam int IdxW = $clog2(MAX_NODES);
  logic [4:0] node_count;
  logic [3:0] basis_index;
  logic [30:0] step_h;
  lbe_pkg::lbe_cmd_t cmd;
  lbe_pkg::lbe_stat_t stat;
  logic [IdxW-1:0] j_idx, k_idx;
  logic tbl_we;
  logic signed [31:0] dp_result;
  logic dp_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= lbe_pkg::NodeCountReset;
      basis_index <= '0;
      step_h <= lbe_pkg::StepHReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbe_pkg::RegNodeCount: node_count <= cfg_data[4:0];
        lbe_pkg::RegBasisIndex: basis_index <= cfg_data[3:0];
        lbe_pkg::RegStepH: step_h <= cfg_data;
        default: ;
      endcase
    end
  end

  lbe_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .node_slot(node_slot), .node_count(node_count), .basis_index(basis_index),
    .stat(stat), .dp_result(dp_result), .dp_ovf(dp_ovf), .cmd(cmd), .j_idx(j_idx),
    .k_idx(k_idx), .tbl_we(tbl_we), .out_valid(out_valid), .out_ready(out_ready),
    .basis_result(basis_result), .status(status)
  );

  lbe_datapath #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .j_idx(j_idx), .k_idx(k_idx), .tbl_we(tbl_we),
    .tbl_addr(node_slot[IdxW-1:0]), .tbl_data(node_value), .x_in(eval_point),
    .step_h(step_h), .stat(stat), .result(dp_result), .ovf(dp_ovf)
  );
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the Lagrange basis evaluator core.
`timescale 1ns / 1ps
module tb;
  import lbe_pkg::*;

  typedef struct {
    logic [1:0]  act;
    logic [3:0]  slot;
    logic [31:0] nval;
    logic [31:0] xpt;
    bit          has_exp;
    logic [31:0] exp_res;
    logic [1:0]  exp_stat;
  } row_t;

  typedef struct {
    logic [31:0] res;
    logic [1:0]  stat;
  } basis_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 64'd30000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = RegNodeCount;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] action = ActLoad;
  logic [3:0] node_slot = '0;
  logic signed [31:0] node_value = '0;
  logic signed [31:0] eval_point = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] basis_result;
  logic [1:0] status;

  lagrange_basis_eval_core i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .action, .node_slot, .node_value, .eval_point,
    .out_valid, .out_ready, .basis_result, .status
  );

  always #1 clk = ~clk;

  // Shadow state of the block.
  longint nodes[16];
  int unsigned ncount = 2;
  int unsigned kidx = 0;
  longint hstep = 1048576;
  bit written[16];
  basis_t pending_results[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at cycle %0d: %s", cycles, what);
  endtask

  function automatic longint sat_q(input longint v, inout bit ovf);
    if (v > QMAX) begin ovf = 1; return QMAX; end
    if (v < QMIN) begin ovf = 1; return QMIN; end
    return v;
  endfunction

  function automatic longint magnitude(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // Fixed point quotient num * 2^28 / den, capped at 2^40.
  function automatic longint frac_quot(input longint num, input longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    if (q > (64'sd1 << 40)) return 64'sd1 << 40;
    for (int i = 0; i < FracBits; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin r -= den; q++; end
      if (q > (64'sd1 << 40)) return 64'sd1 << 40;
    end
    return q;
  endfunction

  function automatic longint basis_at(input longint x, inout bit eq, inout bit ovf);
    int unsigned n;
    longint prod, num, den, fac, m;
    n = ncount < 2 ? 2 : (ncount > 16 ? 16 : ncount);
    prod = 64'sd1 << FracBits;
    if (kidx >= n) return 0;
    for (int j = 0; j < n; j++) begin
      if (j == kidx) continue;
      num = x - nodes[j];
      den = nodes[kidx] - nodes[j];
      if (den == 0) begin eq = 1; return 0; end
      m = frac_quot(magnitude(num), magnitude(den));
      fac = sat_q(((num < 0) != (den < 0)) ? -m : m, ovf);
      m = (magnitude(prod) * magnitude(fac)) >>> FracBits;
      prod = sat_q(((prod < 0) != (fac < 0)) ? -m : m, ovf);
    end
    return prod;
  endfunction

  function automatic basis_t predict_basis(input logic [1:0] act, input logic [31:0] xraw);
    basis_t r;
    bit eq, ovf;
    longint x, h, res, sum, m;
    longint f[4];
    longint off[4];
    eq = 0;
    ovf = 0;
    x = longint'($signed(xraw));
    if (act == ActEval) begin
      res = basis_at(x, eq, ovf);
    end else begin
      h = hstep == 0 ? 1 : hstep;
      off[0] = 2 * h; off[1] = h; off[2] = -h; off[3] = -2 * h;
      for (int i = 0; i < 4 && !eq; i++) f[i] = basis_at(sat_q(x + off[i], ovf), eq, ovf);
      if (eq) res = 0;
      else begin
        sum = -f[0] + 8 * f[1] - 8 * f[2] + f[3];
        m = frac_quot(magnitude(sum), 12 * h);
        res = sat_q(sum < 0 ? -m : m, ovf);
      end
    end
    r.res = eq ? 32'd0 : res[31:0];
    r.stat = eq ? StatEq : (ovf ? StatSat : StatOk);
    return r;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegNodeCount) ncount = val[4:0];
    else if (idx == RegBasisIndex) kidx = val[3:0];
    else if (idx == RegStepH) hstep = val;
    @(posedge clk);
  endtask

  task automatic random_gap();
    int g;
    g = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) in_valid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  // Sends one word and books its expected result if it yields one. Valid is left
  // high so that a following word can go out back to back; the caller drops it.
  task automatic send_word(input row_t r);
    basis_t b;
    in_valid <= 1'b1;
    action <= r.act;
    node_slot <= r.slot;
    node_value <= r.nval;
    eval_point <= r.xpt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.act == ActLoad) begin
      nodes[r.slot] = longint'($signed(r.nval));
      written[r.slot] = 1;
    end else if (r.act == ActEval || r.act == ActDeriv) begin
      b = predict_basis(r.act, r.xpt);
      if (r.has_exp && (b.res !== r.exp_res || b.stat !== r.exp_stat))
        report($sformatf("typed-in row disagrees with predictor: %h/%0d", b.res, b.stat));
      pending_results.push_back(b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let the last handshake settle.
    repeat (4) @(posedge clk);
  endtask

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    basis_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) report("result word with nothing expected");
      else begin
        e = pending_results.pop_front();
        if (basis_result !== e.res)
          report($sformatf("basis_result %h, expected %h", basis_result, e.res));
        if (status !== e.stat)
          report($sformatf("status %0d, expected %0d", status, e.stat));
      end
    end
  end

  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else begin
        g = $urandom_range(0, 19);
        out_ready <= (g == 0) ? 1'b0 : (g < 4 ? $urandom_range(0, 1) : 1'b1);
      end
    end
  end

  function automatic row_t mk(input logic [1:0] a, input logic [3:0] s, input logic [31:0] v,
                              input logic [31:0] x);
    row_t r;
    r.act = a; r.slot = s; r.nval = v; r.xpt = x;
    r.has_exp = 0; r.exp_res = '0; r.exp_stat = StatOk;
    return r;
  endfunction

  function automatic row_t mkx(input logic [1:0] a, input logic [31:0] x,
                               input logic [31:0] er, input logic [1:0] es);
    row_t r;
    r = mk(a, 4'd0, '0, x);
    r.has_exp = 1; r.exp_res = er; r.exp_stat = es;
    return r;
  endfunction

  initial begin
    row_t dir[$];
    row_t r;
    int n, k, sent;
    for (int i = 0; i < 16; i++) begin nodes[i] = 0; written[i] = 0; end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: nodes 0 and 1.0 with the reset registers.
    dir.push_back(mk(ActLoad, 4'd0, 32'h0000_0000, '0));
    dir.push_back(mk(ActLoad, 4'd1, 32'h1000_0000, '0));
    dir.push_back(mkx(ActEval, 32'h0000_0000, 32'h1000_0000, StatOk));
    dir.push_back(mkx(ActEval, 32'h1000_0000, 32'h0000_0000, StatOk));
    dir.push_back(mk(ActEval, 4'd0, '0, 32'h7FFF_FFFF));
    dir.push_back(mk(ActEval, 4'd0, '0, 32'h8000_0000));
    dir.push_back(mk(ActDeriv, 4'd0, '0, 32'h0800_0000));
    dir.push_back(mk(ActDeriv, 4'd0, '0, 32'h7FFF_FFFF));
    dir.push_back(mk(ActDeriv, 4'd0, '0, 32'h8000_0000));
    dir.push_back(mk(2'd3, 4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Equal nodes give a zero denominator.
    dir.push_back(mk(ActLoad, 4'd1, 32'h0000_0000, '0));
    dir.push_back(mkx(ActEval, 32'h1234_5678, 32'h0, StatEq));
    dir.push_back(mkx(ActDeriv, 32'h1234_5678, 32'h0, StatEq));
    // Node extremes: far apart nodes, then very close ones force saturation.
    dir.push_back(mk(ActLoad, 4'd0, 32'h7FFF_FFFF, '0));
    dir.push_back(mk(ActLoad, 4'd1, 32'h8000_0000, '0));
    dir.push_back(mk(ActEval, 4'd0, '0, 32'h0000_0000));
    dir.push_back(mk(ActLoad, 4'd1, 32'h7FFF_FFFE, '0));
    dir.push_back(mk(ActEval, 4'd0, '0, 32'h8000_0000));
    dir.push_back(mk(ActDeriv, 4'd0, '0, 32'h0000_0000));
    foreach (dir[i]) begin send_word(dir[i]); random_gap(); end
    drain();

    // Fill the whole table, then run an evaluate and a derivative with every register at extremes.
    for (int i = 0; i < 16; i++)
      send_word(mk(ActLoad, i[3:0], 32'(i * 32'h0100_0000) - 32'h0800_0000, '0));
    drain();
    write_reg(RegNodeCount, 31'd16);
    write_reg(RegBasisIndex, 31'd15);
    write_reg(RegStepH, 31'h7FFF_FFFF);
    send_word(mk(ActEval, 4'd0, '0, 32'h0000_0000));
    send_word(mk(ActDeriv, 4'd0, '0, 32'h0000_0000));
    drain();
    // Out of range settings: count above table, index beyond count, zero step.
    write_reg(RegNodeCount, 31'd31);
    write_reg(RegStepH, 31'd0);
    send_word(mk(ActDeriv, 4'd0, '0, 32'h0123_4567));
    drain();
    write_reg(RegNodeCount, 31'd0);
    write_reg(RegBasisIndex, 31'd7);
    send_word(mkx(ActEval, 32'h0000_0000, 32'h0, StatOk));
    drain();
    write_reg(2'd3, 31'h7FFF_FFFF);

    // Long receiver hold-off while words keep coming, so the block backs up.
    hold_off = 1'b1;
    fork
      begin repeat (3000) @(posedge clk); hold_off = 1'b0; end
      repeat (4) send_word(mk(ActEval, 4'd0, '0, $urandom));
    join
    drain();

    // Random phases: reload a set of mostly distinct nodes, then send evaluate and derivative words.
    sent = 0;
    while (sent < 1000) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(2, 16) : $urandom_range(2, 4);
      k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
      write_reg(RegNodeCount, 31'(n));
      write_reg(RegBasisIndex, 31'(k));
      write_reg(RegStepH, $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 1 << 24)));
      for (int i = 0; i < 16; i++) begin
        if (i < n || $urandom_range(0, 3) == 0) begin
          r = mk(ActLoad, i[3:0], '0, $urandom);
          r.nval = $urandom_range(0, 7) == 0 ? $urandom : 32'($signed(i * 32'h0040_0000)
                   + $signed(32'($urandom_range(0, 32'h003F_FFFF))) - 32'sh0200_0000);
          if ($urandom_range(0, 19) == 0 && i > 0) r.nval = 32'(nodes[0]);
          send_word(r);
          sent++;
        end
      end
      repeat ($urandom_range(2, 8)) begin
        r = mk($urandom_range(0, 5) == 0 ? ActDeriv : ActEval, 4'd0, '0, $urandom);
        if ($urandom_range(0, 1)) r.xpt = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        if ($urandom_range(0, 15) == 0) r.act = 2'd3;
        send_word(r);
        sent++;
        random_gap();
      end
      drain();
    end

    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* lagrange_basis_eval_core.f */
rtl/lbe_pkg.sv
rtl/lbe_div.sv
rtl/lbe_datapath.sv
rtl/lbe_ctrl.sv
rtl/lagrange_basis_eval_core.sv
dv/tb.sv
